>>> design/sts_pkg.sv
// Shared constants, payload types and helper functions for the sum tree block.
`timescale 1ns / 1ps

package sts_pkg;

  // Tree shape: 2^DEPTH leaves. Node memory uses heap order from address 1.
  localparam int DEPTH      = 10;
  localparam int NODE_AW    = DEPTH + 1;
  localparam int NODE_COUNT = 2 ** NODE_AW;
  localparam int WORD_W     = 32;
  localparam int IDX_W      = 10;

  localparam logic [NODE_AW-1:0] LEAF_COUNT = NODE_AW'(1) << DEPTH;

  // Operation codes.
  localparam logic [1:0] FN_SET    = 2'd0;
  localparam logic [1:0] FN_APPEND = 2'd1;
  localparam logic [1:0] FN_FIND   = 2'd2;
  localparam logic [1:0] FN_READ   = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [IDX_W-1:0]  leaf_index;
    logic [WORD_W-1:0] weight;
    logic [WORD_W-1:0] query;
  } sts_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  found_leaf;
    logic [WORD_W-1:0] leaf_value;
    logic [WORD_W-1:0] total;
  } sts_out_t;

  // One cycle of node memory traffic: one write and one read.
  typedef struct packed {
    logic               wr_en;
    logic [NODE_AW-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               rd_en;
    logic [NODE_AW-1:0] rd_addr;
  } mem_req_t;

  // Wrap an external leaf index to the leaves that exist.
  function automatic logic [DEPTH-1:0] leaf_of(input logic [IDX_W-1:0] idx);
    logic [DEPTH+IDX_W-1:0] wide;
    wide = {{DEPTH{1'b0}}, idx};
    return wide[DEPTH-1:0];
  endfunction

  // Fit a leaf position into the result field.
  function automatic logic [IDX_W-1:0] found_of(input logic [DEPTH-1:0] pos);
    logic [DEPTH+IDX_W-1:0] wide;
    wide = {{IDX_W{1'b0}}, pos};
    return wide[IDX_W-1:0];
  endfunction

endpackage

>>> design/sum_tree_weighted_select.sv
// Top level of the sum tree: sequencer, node memory and result register.
`timescale 1ns / 1ps

// Weighted selection over a binary sum tree of 2^DEPTH 32-bit leaves, one
// operation per transfer: set a leaf, append a leaf, find the leaf whose prefix
// range holds a query, or read a leaf; each result also carries the root total.
// Operations run one at a time. Set and append write the leaf and walk up to the
// root, and find walks down from the root, one tree level per cycle; read
// fetches the leaf, and a find that misses or an append to a full tree goes
// straight to the result. After reset the block clears all 2^(DEPTH+1) node
// memory entries, one entry a cycle, holding in_stall high. The result register
// lets the next operation be taken while a result is still stalled at the output.
module sum_tree_weighted_select
  import sts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  sts_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sts_out_t out_data
);

  logic              res_valid;
  logic              res_ready;
  sts_out_t          res_data;
  mem_req_t          mem_req;
  logic [WORD_W-1:0] mem_rdata;

  sts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  sts_node_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // The result register takes a new result whenever it is empty or being drained.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res_data;
    end
  end

endmodule

>>> design/sts_node_mem.sv
// Node sum memory: one write port and one registered read port.
`timescale 1ns / 1ps

module sts_node_mem
  import sts_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [NODE_COUNT];

  // Write and read in the same cycle; the read data is registered and shows in the cycle after.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

endmodule

>>> design/sts_ctrl.sv
// Operation sequencer: clearing pass, leaf update walk, prefix search walk and leaf read.
`timescale 1ns / 1ps

module sts_ctrl
  import sts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sts_in_t           in_data,
  output logic              res_valid,
  input  logic              res_ready,
  output sts_out_t          res_data,
  output mem_req_t          mem_req,
  input  logic [WORD_W-1:0] mem_rdata
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CLEAR = 8'b00000010,
    S_LEAF  = 8'b00000100,
    S_UP    = 8'b00001000,
    S_FETCH = 8'b00010000,
    S_DOWN  = 8'b00100000,
    S_READ  = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t             state;
  logic [1:0]         op;
  logic [NODE_AW-1:0] addr;
  logic [WORD_W-1:0]  acc;
  logic [NODE_AW-1:0] clr_addr;
  logic [NODE_AW-1:0] used_count;
  logic [WORD_W-1:0]  total;
  logic [1:0]         status;
  logic [IDX_W-1:0]   found;
  logic [WORD_W-1:0]  value;

  logic               accept;
  logic [WORD_W-1:0]  sum;
  logic [NODE_AW-1:0] parent;
  logic               at_root;
  logic               take_right;
  logic [NODE_AW-1:0] chosen;
  logic               at_leaf;
  logic [NODE_AW-1:0] child;

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);

  // Datapath for one tree level: parent sum going up, left-sum compare going down.
  always_comb begin
    sum        = acc + mem_rdata;
    parent     = addr >> 1;
    at_root    = (parent == NODE_AW'(1));
    take_right = (mem_rdata <= acc);
    chosen     = take_right ? (addr | NODE_AW'(1)) : addr;
    at_leaf    = chosen[NODE_AW-1];
    child      = {chosen[NODE_AW-2:0], 1'b0};
  end

  // Memory traffic for the current step.
  always_comb begin
    mem_req = '0;
    case (state)
      S_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = clr_addr;
        mem_req.wr_data = '0;
      end
      S_LEAF: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = addr;
        mem_req.wr_data = acc;
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = addr ^ NODE_AW'(1);
      end
      S_UP: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = parent;
        mem_req.wr_data = sum;
        mem_req.rd_en   = !at_root;
        mem_req.rd_addr = parent ^ NODE_AW'(1);
      end
      S_FETCH: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = addr;
      end
      S_DOWN: begin
        mem_req.rd_en   = !at_leaf;
        mem_req.rd_addr = child;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  // Control state: sequencing, clearing pass, fill count and root total.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      used_count <= '0;
      total      <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + NODE_AW'(1);
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (in_data.func)
              FN_SET: begin
                state <= S_LEAF;
              end
              FN_APPEND: begin
                if (used_count == LEAF_COUNT) begin
                  state <= S_DONE;
                end else begin
                  used_count <= used_count + NODE_AW'(1);
                  state      <= S_LEAF;
                end
              end
              FN_FIND: begin
                state <= (in_data.query >= total) ? S_DONE : S_FETCH;
              end
              default: begin
                state <= S_FETCH;
              end
            endcase
          end
        end
        S_LEAF: begin
          state <= S_UP;
        end
        S_UP: begin
          if (at_root) begin
            total <= sum;
            state <= S_DONE;
          end
        end
        S_FETCH: begin
          state <= (op == FN_FIND) ? S_DOWN : S_READ;
        end
        S_DOWN: begin
          if (at_leaf) begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          state <= S_DONE;
        end
        default: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Working registers and result fields.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op     <= in_data.func;
          status <= ST_OK;
          found  <= '0;
          value  <= '0;
          case (in_data.func)
            FN_SET: begin
              addr <= {1'b1, leaf_of(in_data.leaf_index)};
              acc  <= in_data.weight;
            end
            FN_APPEND: begin
              addr <= {1'b1, used_count[DEPTH-1:0]};
              acc  <= in_data.weight;
              if (used_count == LEAF_COUNT) begin
                status <= ST_FULL;
              end
            end
            FN_FIND: begin
              addr <= NODE_AW'(2);
              acc  <= in_data.query;
              if (in_data.query >= total) begin
                status <= ST_NOT_FOUND;
              end
            end
            default: begin
              addr <= {1'b1, leaf_of(in_data.leaf_index)};
            end
          endcase
        end
      end
      S_UP: begin
        addr <= parent;
        acc  <= sum;
      end
      S_DOWN: begin
        if (take_right) begin
          acc <= acc - mem_rdata;
        end
        if (at_leaf) begin
          found <= found_of(chosen[DEPTH-1:0]);
        end else begin
          addr <= child;
        end
      end
      S_READ: begin
        value <= mem_rdata;
      end
      default: begin
        op <= op;
      end
    endcase
  end

  assign res_valid           = (state == S_DONE);
  assign res_data.status     = status;
  assign res_data.found_leaf = found;
  assign res_data.leaf_value = value;
  assign res_data.total      = total;

endmodule

>>> design/sts_checker.sv
// Port-level checks for the sum tree, bound to the top level.
`timescale 1ns / 1ps

module sts_checker
  import sts_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input sts_out_t out_data
);

  // Reset empties the output and starts the clearing pass.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && in_stall)
    else $error("output valid or input open right after reset");

  // Operations run one at a time: a transfer in closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transfer");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Only defined status codes leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status == ST_OK || out_data.status == ST_NOT_FOUND ||
                  out_data.status == ST_FULL)
    else $error("undefined status code");

  // A failed operation reports no leaf and no value.
  a_fail_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |->
      out_data.found_leaf == '0 && out_data.leaf_value == '0)
    else $error("failed operation carries a leaf or value");

endmodule

bind sum_tree_weighted_select sts_checker u_sts_checker (.*);
